// ----- rtl/core/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants for the resistance-to-temperature block
// Holds the configuration and result structures, the fault codes, the
// register indexes and the fixed-point constants of both linearization paths.
// ----------------------------------------------------------------------------
package rtt_pkg;

   // Pipeline depth from input register to output register.
   localparam int LAT      = 65;
   // Depth of the platinum RTD path; it is delayed to match the thermistor path.
   localparam int RTD_LAT  = 29;
   localparam int RTD_PAD  = LAT - RTD_LAT;

   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 48;

   // Register indexes on the configuration port.
   localparam logic [CSR_AW-1:0] CSR_SENSOR_KIND = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_RTD_NOMINAL = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_COEFF_A     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_COEFF_B     = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_COEFF_C     = 3'd4;

   localparam logic [13:0]        RTD_NOMINAL_RST = 14'd1000;
   localparam logic signed [47:0] COEFF_A_RST     = 48'sd316746283000;
   localparam logic signed [47:0] COEFF_B_RST     = 48'sd66065600000;
   localparam logic signed [47:0] COEFF_C_RST     = 48'sd24112100;

   // Output range bounds.
   localparam logic signed [18:0] TQ_MAX = 19'sh3FFFF;
   localparam logic signed [18:0] TQ_MIN = 19'sh40000;

   // Callendar-Van Dusen constants (radicand scaled by 1e16 * 256 * R0).
   localparam logic [45:0] RTD_K256  = 46'd45006105760000;
   localparam logic [34:0] RTD_C     = 35'd23100000000;
   // Linear term and rounding offset plus 1848 * 2^19, which keeps the dividend positive.
   localparam logic [31:0] RTD_XOFS  = 32'd2569499548;
   localparam logic [32:0] RTD_RECIP = 33'd4759790597;
   localparam int          RTD_RSH   = 43;

   // Thermistor constants.
   localparam logic [29:0] LN2_Q30    = 30'd744261118;
   localparam logic signed [31:0] KELVIN_Q16 = 32'sd17901158;

   typedef enum logic [1:0] {
      FAULT_OK    = 2'd0,
      FAULT_RANGE = 2'd1,
      FAULT_ZERO  = 2'd2
   } fault_type;

   typedef struct packed {
      logic              sensor_kind;
      logic [13:0]       rtd_nominal_ohms;
      logic signed [47:0] coeff_a;
      logic signed [47:0] coeff_b;
      logic signed [47:0] coeff_c;
   } cfg_type;

   typedef struct packed {
      logic signed [18:0] temperature_q8;
      fault_type          fault;
   } res_type;

endpackage

// ----- rtl/core/rtt_rtd.sv -----
// ----------------------------------------------------------------------------
// rtt_rtd: platinum RTD path
// Solves the Callendar-Van Dusen quadratic with a radix-2 divider and a
// bit-pair square root, both spread over pipeline stages.
// ----------------------------------------------------------------------------
module rtt_rtd (
   input  logic             clock,
   input  logic             adv,
   input  logic [23:0]      resistance_q8,
   input  rtt_pkg::cfg_type cfg,
   output rtt_pkg::res_type res
);

   localparam int DIV_ST = 8;
   localparam int SQ_ST  = 16;
   localparam int NEG_LEN = 27;

   typedef struct packed {
      logic [13:0] rem;
      logic [63:0] dvd;
   } div_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sq_type;

   // Eight restoring division steps; the quotient shifts in as the dividend leaves.
   function automatic div_type div_steps(input div_type x, input logic [13:0] d);
      logic [14:0] t;
      div_type     y;
      y = x;
      for (int i = 0; i < 8; i++) begin
         t = {y.rem, y.dvd[63]};
         if (t >= {1'b0, d}) begin
            y.rem = 14'(t - {1'b0, d});
            y.dvd = {y.dvd[62:0], 1'b1};
         end else begin
            y.rem = t[13:0];
            y.dvd = {y.dvd[62:0], 1'b0};
         end
      end
      return y;
   endfunction

   // Two root bits per stage.
   function automatic sq_type sq_steps(input sq_type x);
      logic [34:0] t;
      logic [34:0] tr;
      sq_type      y;
      y = x;
      for (int i = 0; i < 2; i++) begin
         t  = {y.rem, y.rad[63:62]};
         tr = {1'b0, y.root, 2'b01};
         if (t >= tr) begin
            y.rem  = 33'(t - tr);
            y.root = {y.root[30:0], 1'b1};
         end else begin
            y.rem  = t[32:0];
            y.root = {y.root[30:0], 1'b0};
         end
         y.rad = {y.rad[61:0], 2'b00};
      end
      return y;
   endfunction

   logic [13:0]        r0;
   logic [59:0]        kr_ff;
   logic [58:0]        cr_ff;
   logic [60:0]        diff;
   logic [59:0]        n_ff;
   logic [NEG_LEN-1:0] neg_ff;
   div_type            div_ff [DIV_ST];
   sq_type             sq_ff  [SQ_ST];
   logic [31:0]        x_ff;
   logic [64:0]        prod_ff;
   logic signed [22:0] t;
   rtt_pkg::res_type   res_in;
   rtt_pkg::res_type   res_ff;

   // A nominal resistance of zero is taken as one ohm.
   assign r0   = (cfg.rtd_nominal_ohms == 14'd0) ? 14'd1 : cfg.rtd_nominal_ohms;
   assign diff = {1'b0, kr_ff} - {2'b00, cr_ff};
   assign t    = $signed({1'b0, prod_ff[64:rtt_pkg::RTD_RSH]}) - 23'sd524288;

   always_comb begin
      res_in.temperature_q8 = t[18:0];
      res_in.fault          = rtt_pkg::FAULT_OK;
      if (neg_ff[NEG_LEN-1]) begin
         res_in.temperature_q8 = rtt_pkg::TQ_MAX;
         res_in.fault          = rtt_pkg::FAULT_RANGE;
      end else if (t > 23'sd262143) begin
         res_in.temperature_q8 = rtt_pkg::TQ_MAX;
         res_in.fault          = rtt_pkg::FAULT_RANGE;
      end else if (t < -23'sd262144) begin
         res_in.temperature_q8 = rtt_pkg::TQ_MIN;
         res_in.fault          = rtt_pkg::FAULT_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kr_ff   <= 60'(rtt_pkg::RTD_K256) * 60'(r0);
         cr_ff   <= 59'(rtt_pkg::RTD_C) * 59'(resistance_q8);
         n_ff    <= diff[60] ? 60'd0 : diff[59:0];
         neg_ff  <= {neg_ff[NEG_LEN-2:0], diff[60]};
         div_ff[0] <= div_steps({2'b00, n_ff[59:48], n_ff[47:0], 16'd0}, r0);
         for (int i = 1; i < DIV_ST; i++) begin
            div_ff[i] <= div_steps(div_ff[i-1], r0);
         end
         sq_ff[0] <= sq_steps({33'd0, 32'd0, div_ff[DIV_ST-1].dvd});
         for (int i = 1; i < SQ_ST; i++) begin
            sq_ff[i] <= sq_steps(sq_ff[i-1]);
         end
         x_ff    <= rtt_pkg::RTD_XOFS - sq_ff[SQ_ST-1].root;
         prod_ff <= 65'(x_ff) * 65'(rtt_pkg::RTD_RECIP);
         res_ff  <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/rtt_therm.sv -----
// ----------------------------------------------------------------------------
// rtt_therm: thermistor path
// Log by repeated squaring, Steinhart-Hart polynomial in split products and a
// radix-2 reciprocal divider, one multiplier or divider step per stage.
// ----------------------------------------------------------------------------
module rtt_therm (
   input  logic             clock,
   input  logic             adv,
   input  logic [23:0]      resistance_q8,
   input  rtt_pkg::cfg_type cfg,
   output rtt_pkg::res_type res
);

   localparam int SQR_N  = 24;
   localparam int DV_ST  = 30;
   localparam int FL_LEN = 31;

   typedef struct packed {
      logic [59:0] rem;
      logic [29:0] q;
      logic [59:0] d;
   } dv_type;

   function automatic dv_type dv_step(input dv_type x);
      logic [60:0] t;
      dv_type      y;
      y = x;
      t = {y.rem, 1'b0};
      if (t >= {1'b0, y.d}) begin
         y.rem = 60'(t - {1'b0, y.d});
         y.q   = {y.q[28:0], 1'b1};
      end else begin
         y.rem = t[59:0];
         y.q   = {y.q[28:0], 1'b0};
      end
      return y;
   endfunction

   logic [4:0]          e;
   logic [30:0]         m0;
   logic [63:0]         zero_ff;
   logic [4:0]          e_ff   [SQR_N+1];
   logic [30:0]         m0_ff;
   logic [61:0]         p_ff   [SQR_N];
   logic [31:0]         nm     [1:SQR_N];
   logic [23:0]         frac_ff [SQR_N-1];
   logic [23:0]         frac24;
   logic signed [29:0]  lg;
   logic [28:0]         lmag_ff;
   logic [3:0]          sgn_ff;
   logic [58:0]         mag_ff;
   logic [27:0]         al;
   logic [27:0]         al_ff;
   logic [27:0]         al2_ff;
   logic [55:0]         sq_ff;
   logic [59:0]         cub_ff;
   logic signed [28:0]  l_ff;
   logic signed [36:0]  l3_ff;
   logic signed [52:0]  pbh_ff;
   logic signed [53:0]  pbl_ff;
   logic signed [60:0]  pch_ff;
   logic signed [61:0]  pcl_ff;
   logic signed [95:0]  yab_ff;
   logic signed [95:0]  yc_ff;
   logic signed [95:0]  y_ff;
   logic [95:0]         ya;
   logic [FL_LEN-1:0]   yneg_ff;
   logic [FL_LEN-1:0]   small_ff;
   logic [59:0]         ys_ff;
   dv_type              dv_ff [DV_ST];
   logic signed [31:0]  zs;
   logic signed [31:0]  tk;
   logic [31:0]         d;
   logic [23:0]         tt;
   rtt_pkg::res_type    res_in;
   rtt_pkg::res_type    res_ff;

   // Position of the leading one, then normalize the mantissa to Q30.
   always_comb begin
      e = 5'd0;
      for (int i = 1; i < 24; i++) begin
         if (resistance_q8[i]) e = 5'(i);
      end
      m0 = 31'({30'd0, resistance_q8} << (5'd30 - e));
   end

   // Each squared mantissa gives one fraction bit and is brought back below two.
   always_comb begin
      for (int j = 1; j <= SQR_N; j++) begin
         nm[j][31]   = p_ff[j-1][61];
         nm[j][30:0] = p_ff[j-1][61] ? p_ff[j-1][61:31] : p_ff[j-1][60:30];
      end
   end

   assign frac24 = {frac_ff[SQR_N-2][22:0], nm[SQR_N][31]};
   assign lg     = $signed({1'b0, e_ff[SQR_N], frac24}) - 30'sd134217728;
   assign al     = mag_ff[57:30];
   assign ya     = y_ff[95] ? 96'(-y_ff) : 96'(y_ff);

   assign zs = yneg_ff[FL_LEN-1] ? -$signed({2'b00, dv_ff[DV_ST-1].q})
                                 :  $signed({2'b00, dv_ff[DV_ST-1].q});
   assign tk = zs - rtt_pkg::KELVIN_Q16;
   assign d  = tk[31] ? 32'(-tk) : 32'(tk);
   assign tt = 24'((d + 32'd128) >> 8);

   always_comb begin
      res_in.temperature_q8 = $signed(tt[18:0]);
      res_in.fault          = rtt_pkg::FAULT_OK;
      if (zero_ff[63]) begin
         res_in.temperature_q8 = '0;
         res_in.fault          = rtt_pkg::FAULT_ZERO;
      end else if (small_ff[FL_LEN-1] || (tt > 24'd262143)) begin
         res_in.temperature_q8 = rtt_pkg::TQ_MAX;
         res_in.fault          = rtt_pkg::FAULT_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= {zero_ff[62:0], (resistance_q8 == 24'd0)};
         e_ff[0] <= e;
         for (int i = 1; i <= SQR_N; i++) begin
            e_ff[i] <= e_ff[i-1];
         end
         m0_ff   <= m0;
         p_ff[0] <= 62'(m0_ff) * 62'(m0_ff);
         for (int j = 1; j < SQR_N; j++) begin
            p_ff[j] <= 62'(nm[j][30:0]) * 62'(nm[j][30:0]);
         end
         frac_ff[0] <= {23'd0, nm[1][31]};
         for (int j = 1; j < SQR_N - 1; j++) begin
            frac_ff[j] <= {frac_ff[j-1][22:0], nm[j+1][31]};
         end
         sgn_ff  <= {sgn_ff[2:0], lg[29]};
         lmag_ff <= lg[29] ? 29'(-lg) : lg[28:0];
         mag_ff  <= 59'(lmag_ff) * 59'(rtt_pkg::LN2_Q30);
         al_ff   <= al;
         sq_ff   <= 56'(al) * 56'(al);
         al2_ff  <= al_ff;
         cub_ff  <= 60'(sq_ff[55:24]) * 60'(al_ff);
         l_ff    <= sgn_ff[3] ? -$signed({1'b0, al2_ff}) : $signed({1'b0, al2_ff});
         l3_ff   <= sgn_ff[3] ? -$signed({1'b0, cub_ff[59:24]})
                              :  $signed({1'b0, cub_ff[59:24]});
         pbh_ff  <= $signed(cfg.coeff_b[47:24]) * l_ff;
         pbl_ff  <= $signed({1'b0, cfg.coeff_b[23:0]}) * l_ff;
         pch_ff  <= $signed(cfg.coeff_c[47:24]) * l3_ff;
         pcl_ff  <= $signed({1'b0, cfg.coeff_c[23:0]}) * l3_ff;
         yab_ff  <= ((96'(cfg.coeff_a) + 96'(pbh_ff)) <<< 24) + 96'(pbl_ff);
         yc_ff   <= (96'(pch_ff) <<< 24) + 96'(pcl_ff);
         y_ff    <= yab_ff + yc_ff;
         yneg_ff  <= {yneg_ff[FL_LEN-2:0], y_ff[95]};
         small_ff <= {small_ff[FL_LEN-2:0], (ya[95:59] == 37'd0)};
         ys_ff    <= ya[84:25];
         // 2^63 / ys: the quotient fits in the low 30 bits, so start from 2^33.
         dv_ff[0] <= dv_step({60'h0_0002_0000_0000, 30'd0, ys_ff});
         for (int i = 1; i < DV_ST; i++) begin
            dv_ff[i] <= dv_step(dv_ff[i-1]);
         end
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/resistance_to_temperature.sv -----
// ----------------------------------------------------------------------------
// resistance_to_temperature: sensor resistance to temperature linearizer
// Latency from input transaction to result is set by the thermistor path
// (24 squaring stages for the log and 30 divider stages for 1/T).
// Throughput is one transaction per cycle while the result side is ready.
// Reset (synchronous, active high) empties the pipeline and restores the
// register reset values.
// ----------------------------------------------------------------------------
module resistance_to_temperature (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel: tdata = resistance_q8[23:0].
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,
   // Result channel: tdata = temperature_q8[18:0], zero fill above.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata,
   // Result channel: tuser = fault[1:0].
   output logic [1:0]                  rsp_tuser,
   // Configuration write port.
   input  logic                        csr_we,
   input  logic [rtt_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [rtt_pkg::CSR_DW-1:0]  csr_wdata
);

   // Configuration registers. The user must change them only while the pipeline
   // is empty (not enforced by the block); both paths read them directly, no copy.
   rtt_pkg::cfg_type cfg_ff;
   rtt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            rtt_pkg::CSR_SENSOR_KIND: cfg_in.sensor_kind      = csr_wdata[0];
            rtt_pkg::CSR_RTD_NOMINAL: cfg_in.rtd_nominal_ohms = csr_wdata[13:0];
            rtt_pkg::CSR_COEFF_A:     cfg_in.coeff_a          = $signed(csr_wdata);
            rtt_pkg::CSR_COEFF_B:     cfg_in.coeff_b          = $signed(csr_wdata);
            rtt_pkg::CSR_COEFF_C:     cfg_in.coeff_c          = $signed(csr_wdata);
            default:                  cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_kind      <= 1'b0;
         cfg_ff.rtd_nominal_ohms <= rtt_pkg::RTD_NOMINAL_RST;
         cfg_ff.coeff_a          <= rtt_pkg::COEFF_A_RST;
         cfg_ff.coeff_b          <= rtt_pkg::COEFF_B_RST;
         cfg_ff.coeff_c          <= rtt_pkg::COEFF_C_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The whole pipeline advances together. It holds only when the output
   // register carries a result that the result side has not taken, so a
   // stall neither drops nor duplicates a transaction, and a new transaction
   // enters in the same cycle that the output one leaves.
   logic                    adv;
   logic [rtt_pkg::LAT-1:0] vld_ff;
   logic [rtt_pkg::LAT-1:0] vld_in;

   assign adv        = !vld_ff[rtt_pkg::LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign vld_in     = adv ? {vld_ff[rtt_pkg::LAT-2:0], req_tvalid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Both paths compute every transaction; the sensor kind picks one at the end.
   rtt_pkg::res_type rtd_res;
   rtt_pkg::res_type therm_res;
   rtt_pkg::res_type pad_ff [rtt_pkg::RTD_PAD];
   rtt_pkg::res_type out_res;

   rtt_rtd u_rtd (
      .clock         (clock),
      .adv           (adv),
      .resistance_q8 (req_tdata),
      .cfg           (cfg_ff),
      .res           (rtd_res)
   );

   rtt_therm u_therm (
      .clock         (clock),
      .adv           (adv),
      .resistance_q8 (req_tdata),
      .cfg           (cfg_ff),
      .res           (therm_res)
   );

   // The RTD path is shorter; this delay line lines it up with the thermistor path.
   always_ff @(posedge clock) begin
      if (adv) begin
         pad_ff[0] <= rtd_res;
         for (int i = 1; i < rtt_pkg::RTD_PAD; i++) begin
            pad_ff[i] <= pad_ff[i-1];
         end
      end
   end

   assign out_res    = cfg_ff.sensor_kind ? therm_res : pad_ff[rtt_pkg::RTD_PAD-1];
   assign rsp_tvalid = vld_ff[rtt_pkg::LAT-1];
   assign rsp_tdata  = {5'd0, out_res.temperature_q8};
   assign rsp_tuser  = out_res.fault;

endmodule

// ----- rtl/core/rtt_checker.sv -----
// ----------------------------------------------------------------------------
// rtt_checker: port-level checks for the linearizer
// Watches the top-level ports and flags handshake and result-code slips.
// ----------------------------------------------------------------------------
module rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With no result waiting, the block must take input.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // A zero-resistance fault always reports zero degrees.
   a_zero_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rtt_pkg::FAULT_ZERO) |-> (rsp_tdata == 24'd0))
      else $error("zero-resistance fault with nonzero temperature");

   // Only defined fault codes appear, and the fill bits stay clear.
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3) && (rsp_tdata[23:19] == 5'd0))
      else $error("undefined fault code or fill bits set");

endmodule

bind resistance_to_temperature rtt_checker u_rtt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
